@@ hdl/keypad_press_window_detector_defines.svh @@
// ----------------------------------------------------------------------------
// keypad press window detector assertion macros
// shared assertion forms, clocked on clk and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PRESS_WINDOW_DETECTOR_DEFINES_SVH
`define KEYPAD_PRESS_WINDOW_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define KPWD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kpwd assertion failed");

// next-cycle implication
`define KPWD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kpwd assertion failed");

`else

`define KPWD_ASSERT_IMP(label, ante, cons)
`define KPWD_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ hdl/kpwd_pkg.sv @@
// ----------------------------------------------------------------------------
// kpwd_pkg
// constants, register codes and types of the keypad press window detector
// ----------------------------------------------------------------------------
package kpwd_pkg;

	localparam int KEY_ROWS  = 4;
	localparam int KEY_COLS  = 4;
	localparam int KEY_COUNT = KEY_ROWS * KEY_COLS;
	localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

	localparam int ROW_W       = 2;
	localparam int COL_W       = 2;
	localparam int TIME_W      = 32;
	localparam int MS_W        = 16;
	localparam int KEY_INDEX_W = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [MS_W-1:0] PRESS_MIN_RST  = 16'd50;
	localparam logic [MS_W-1:0] PRESS_MAX_RST  = 16'd1000;
	localparam logic            ACTIVE_LOW_RST = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_MIN  = 2'd0,
		REG_PRESS_MAX  = 2'd1,
		REG_ACTIVE_LOW = 2'd2
	} cfg_reg_t;

	// one write into the key store
	typedef struct packed {
		logic                 en;
		logic [KEY_IDX_W-1:0] key;
		logic                 armed;
		logic [TIME_W-1:0]    start;
	} key_wr_t;

endpackage

@@ hdl/keypad_press_window_detector.sv @@
// ----------------------------------------------------------------------------
// keypad_press_window_detector
// arms a key on an active sample and reports a press when the key is seen
// active again inside the min/max window
// ----------------------------------------------------------------------------
//
//  channel  handshake          payload
//  -------  -----------------  -------------------------------------------
//  in       in_valid/in_stall  row, col, level, now_ms
//  out      out_valid/out_stall key_pressed, key_index
//  cfg      cfg_valid/cfg_ready cfg_index, cfg_data
//
// one request per cycle sustained while out_stall is low; result valid rises
// once the request has passed the input register and then the result register
// the key store update is done in the same cycle as the result register
// load, so a request for the same key right behind sees the new state
// in_stall rises only when both the input stage and the result register
// are full and out_stall is high; cfg_ready is always high
// reset clears all armed flags and loads the register reset values
// ----------------------------------------------------------------------------
`include "keypad_press_window_detector_defines.svh"

module keypad_press_window_detector (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [kpwd_pkg::ROW_W-1:0]      row,
	input  logic [kpwd_pkg::COL_W-1:0]      col,
	input  logic                            level,
	input  logic [kpwd_pkg::TIME_W-1:0]     now_ms,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            key_pressed,
	output logic [kpwd_pkg::KEY_INDEX_W-1:0] key_index,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kpwd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kpwd_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [kpwd_pkg::MS_W-1:0] press_min_q;
	logic [kpwd_pkg::MS_W-1:0] press_max_q;
	logic                      active_low_q;

	logic                        valid_s1;
	logic [kpwd_pkg::ROW_W-1:0]  row_s1;
	logic [kpwd_pkg::COL_W-1:0]  col_s1;
	logic                        level_s1;
	logic [kpwd_pkg::TIME_W-1:0] now_s1;

	logic                             out_valid_q;
	logic                             key_pressed_q;
	logic [kpwd_pkg::KEY_INDEX_W-1:0] key_index_q;

	logic                          in_acc;
	logic                          adv_s1;
	logic                          in_range;
	logic                          active;
	logic [31:0]                   idx_full;
	logic [kpwd_pkg::KEY_IDX_W-1:0] key;
	logic                          rd_armed;
	logic [kpwd_pkg::TIME_W-1:0]   rd_start;
	logic [kpwd_pkg::TIME_W-1:0]   elapsed;
	logic                          over_max;
	logic                          over_min;
	logic                          hit;
	logic                          pressed;
	kpwd_pkg::key_wr_t             wr;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_min_q  <= kpwd_pkg::PRESS_MIN_RST;
			press_max_q  <= kpwd_pkg::PRESS_MAX_RST;
			active_low_q <= kpwd_pkg::ACTIVE_LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				kpwd_pkg::REG_PRESS_MIN:  press_min_q  <= cfg_data;
				kpwd_pkg::REG_PRESS_MAX:  press_max_q  <= cfg_data;
				kpwd_pkg::REG_ACTIVE_LOW: active_low_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv_s1);
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_s1   <= row;
			col_s1   <= col;
			level_s1 <= level;
			now_s1   <= now_ms;
		end
		if (adv_s1) begin
			key_pressed_q <= pressed;
			key_index_q   <= pressed ? idx_full[kpwd_pkg::KEY_INDEX_W-1:0] : '0;
		end
	end

	// key evaluation
	assign in_range = (int'(row_s1) < kpwd_pkg::KEY_ROWS) &&
		(int'(col_s1) < kpwd_pkg::KEY_COLS);
	assign active   = level_s1 ^ active_low_q;
	assign idx_full = 32'(int'(row_s1) * kpwd_pkg::KEY_COLS + int'(col_s1));
	assign key      = idx_full[kpwd_pkg::KEY_IDX_W-1:0];

	kpwd_key_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_key   (key),
		.rd_armed (rd_armed),
		.rd_start (rd_start),
		.wr       (wr)
	);

	assign elapsed  = now_s1 - rd_start;
	assign over_max = elapsed > {{(kpwd_pkg::TIME_W-kpwd_pkg::MS_W){1'b0}}, press_max_q};
	assign over_min = elapsed > {{(kpwd_pkg::TIME_W-kpwd_pkg::MS_W){1'b0}}, press_min_q};
	assign hit      = in_range && active;
	// max test wins over min
	assign pressed  = hit && rd_armed && !over_max && over_min;

	always_comb begin
		wr.en    = adv_s1 && hit && (!rd_armed || over_max || over_min);
		wr.key   = key;
		wr.armed = !rd_armed;
		wr.start = rd_armed ? '0 : now_s1;
	end

	assign out_valid   = out_valid_q;
	assign key_pressed = key_pressed_q;
	assign key_index   = key_index_q;

	`KPWD_ASSERT_IMP(a_stall_only_when_full, in_stall, valid_s1 && out_valid_q && out_stall)
	`KPWD_ASSERT_NXT(a_adv_fills_result, adv_s1, out_valid_q)
	`KPWD_ASSERT_IMP(a_press_disarms, adv_s1 && pressed, wr.en && !wr.armed)

endmodule

@@ hdl/kpwd_key_store.sv @@
// ----------------------------------------------------------------------------
// kpwd_key_store
// per-key armed flag and press start time, one read and one write per cycle
// ----------------------------------------------------------------------------
module kpwd_key_store (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kpwd_pkg::KEY_IDX_W-1:0] rd_key,
	output logic                          rd_armed,
	output logic [kpwd_pkg::TIME_W-1:0]   rd_start,
	input  kpwd_pkg::key_wr_t             wr
);

	logic [kpwd_pkg::KEY_COUNT-1:0] armed_q;
	logic [kpwd_pkg::TIME_W-1:0]    start_q [kpwd_pkg::KEY_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
		end else if (wr.en) begin
			armed_q[wr.key] <= wr.armed;
		end
	end

	// start time only matters while the key is armed
	always_ff @(posedge clk) begin
		if (wr.en) begin
			start_q[wr.key] <= wr.start;
		end
	end

	assign rd_armed = armed_q[rd_key];
	assign rd_start = start_q[rd_key];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the keypad press window detector: scan samples go
// in through a queue-fed driver, every accepted request is run through a local
// key-state predictor, and a monitor compares each result in order
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ITEMS_PER_PHASE = 275;
	localparam int N_PHASES        = 6;
	localparam int CYCLE_LIMIT     = 200000;
	localparam logic [kpwd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [kpwd_pkg::ROW_W-1:0]  row;
		logic [kpwd_pkg::COL_W-1:0]  col;
		logic                        level;
		logic [kpwd_pkg::TIME_W-1:0] now_ms;
	} sample_t;

	typedef struct packed {
		logic                             pressed;
		logic [kpwd_pkg::KEY_INDEX_W-1:0] index;
	} press_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [kpwd_pkg::ROW_W-1:0]       row = '0;
	logic [kpwd_pkg::COL_W-1:0]       col = '0;
	logic                             level = 1'b0;
	logic [kpwd_pkg::TIME_W-1:0]      now_ms = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             key_pressed;
	logic [kpwd_pkg::KEY_INDEX_W-1:0] key_index;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [kpwd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [kpwd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	// predictor state and register copies
	logic [kpwd_pkg::MS_W-1:0]   press_floor_ms = kpwd_pkg::PRESS_MIN_RST;
	logic [kpwd_pkg::MS_W-1:0]   press_ceil_ms  = kpwd_pkg::PRESS_MAX_RST;
	logic                        polarity_low   = kpwd_pkg::ACTIVE_LOW_RST;
	logic                        key_armed[kpwd_pkg::KEY_COUNT];
	logic [kpwd_pkg::TIME_W-1:0] key_down_at[kpwd_pkg::KEY_COUNT];

	sample_t scan_q[$];
	press_t  press_q[$];

	int unsigned snd_idle_pct = 7;
	int unsigned rcv_idle_pct = 45;
	logic        hold_arm = 1'b0;
	logic        hold_used = 1'b0;
	int unsigned hold_left = 0;
	int unsigned err_cnt = 0;
	int unsigned cycle_cnt = 0;

	int unsigned set_min[N_PHASES] = '{50, 0, 65535, 300, 0, 7};
	int unsigned set_max[N_PHASES] = '{1000, 65535, 65535, 100, 0, 40};
	logic        set_low[N_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

	keypad_press_window_detector i_dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		for (int k = 0; k < kpwd_pkg::KEY_COUNT; k++) begin
			key_armed[k]   = 1'b0;
			key_down_at[k] = '0;
		end
	end

	task automatic report_mismatch(string what);
		if (err_cnt < 100)
			$display("mismatch at %0t: %s", $realtime, what);
		err_cnt++;
	endtask

	// next result for one sample; updates the key store copy
	function automatic press_t judge_sample(sample_t s);
		press_t                      res;
		int unsigned                 k;
		logic [kpwd_pkg::TIME_W-1:0] held;
		res = '0;
		if (s.row >= kpwd_pkg::KEY_ROWS || s.col >= kpwd_pkg::KEY_COLS ||
				s.level == polarity_low)
			return res;
		k = s.row * kpwd_pkg::KEY_COLS + s.col;
		if (!key_armed[k]) begin
			key_armed[k]   = 1'b1;
			key_down_at[k] = s.now_ms;
			return res;
		end
		held = s.now_ms - key_down_at[k];
		// max test wins when the window is empty
		if (held > press_ceil_ms) begin
			key_armed[k]   = 1'b0;
			key_down_at[k] = '0;
		end else if (held > press_floor_ms) begin
			res.pressed    = 1'b1;
			res.index      = (kpwd_pkg::KEY_INDEX_W)'(k);
			key_armed[k]   = 1'b0;
			key_down_at[k] = '0;
		end
		return res;
	endfunction

	task automatic push_sample(logic [kpwd_pkg::ROW_W-1:0] r, logic [kpwd_pkg::COL_W-1:0] c,
			logic lv, logic [kpwd_pkg::TIME_W-1:0] t);
		sample_t s;
		s.row    = r;
		s.col    = c;
		s.level  = lv;
		s.now_ms = t;
		scan_q.push_back(s);
	endtask

	task automatic push_noise(logic [kpwd_pkg::TIME_W-1:0] t);
		push_sample((kpwd_pkg::ROW_W)'($urandom), (kpwd_pkg::COL_W)'($urandom),
			1'($urandom), t);
	endtask

	// arm a key, scatter some noise, then hit it again at a chosen distance
	task automatic queue_press_attempt();
		logic [kpwd_pkg::ROW_W-1:0]  r;
		logic [kpwd_pkg::COL_W-1:0]  c;
		logic [kpwd_pkg::TIME_W-1:0] t0;
		logic [kpwd_pkg::TIME_W-1:0] gap;
		r  = (kpwd_pkg::ROW_W)'($urandom_range(0, 3));
		c  = (kpwd_pkg::COL_W)'($urandom_range(0, 3));
		t0 = $urandom;
		push_sample(r, c, !polarity_low, t0);
		repeat ($urandom_range(0, 3)) begin
			if ($urandom_range(0, 1))
				push_sample(r, c, polarity_low, t0 + $urandom_range(0, 2000));
			else
				push_noise(t0 + $urandom_range(0, 3000));
		end
		case ($urandom_range(0, 9))
			0, 1: gap = $urandom_range(0, press_floor_ms);
			2, 3, 4, 5: begin
				if (press_floor_ms < press_ceil_ms)
					gap = $urandom_range(press_floor_ms + 1, press_ceil_ms);
				else
					gap = $urandom_range(0, 70000);
			end
			6: gap = press_ceil_ms;
			7: gap = press_floor_ms + 1;
			8: gap = press_ceil_ms + $urandom_range(1, 3000);
			default: gap = $urandom;
		endcase
		push_sample(r, c, !polarity_low, t0 + gap);
	endtask

	task automatic cfg_write(logic [kpwd_pkg::CFG_IDX_W-1:0] idx,
			logic [kpwd_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == kpwd_pkg::REG_PRESS_MIN)
			press_floor_ms = data;
		else if (idx == kpwd_pkg::REG_PRESS_MAX)
			press_ceil_ms = data;
		else if (idx == kpwd_pkg::REG_ACTIVE_LOW)
			polarity_low = data[0];
	endtask

	task automatic wait_drained();
		while (scan_q.size() != 0 || in_valid || press_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		sample_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			row      <= '0;
			col      <= '0;
			level    <= 1'b0;
			now_ms   <= '0;
		end else begin
			if (in_valid && !in_stall)
				press_q.push_back(judge_sample('{row, col, level, now_ms}));
			if (!in_valid || !in_stall) begin
				if (scan_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
					nxt = scan_q.pop_front();
					in_valid <= 1'b1;
					row      <= nxt.row;
					col      <= nxt.col;
					level    <= nxt.level;
					now_ms   <= nxt.now_ms;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, once
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_arm && !hold_used) begin
			hold_left <= 90;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		press_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (press_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result key_pressed=%0d key_index=%0d",
						key_pressed, key_index));
				end else begin
					want = press_q.pop_front();
					if (key_pressed !== want.pressed)
						report_mismatch($sformatf("key_pressed %0b, expected %0b",
							key_pressed, want.pressed));
					if (key_index !== want.index)
						report_mismatch($sformatf("key_index %0d, expected %0d",
							key_index, want.index));
				end
			end
			out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("keypad_press_window_detector test failed");
			$finish;
		end
	end

	initial begin
		logic [kpwd_pkg::CFG_DATA_W-1:0] pol_word;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed samples at reset settings
		push_sample(2'd0, 2'd0, 1'b1, 32'd0);
		push_sample(2'd0, 2'd0, 1'b1, 32'd50);          // exactly min, still armed
		push_sample(2'd0, 2'd0, 1'b1, 32'd51);
		push_sample(2'd3, 2'd3, 1'b1, 32'hFFFF_FFF0);
		push_sample(2'd3, 2'd3, 1'b0, 32'h0000_0100);   // release leaves the arm alone
		push_sample(2'd3, 2'd3, 1'b1, 32'h0000_03D8);   // wraps, exactly max
		push_sample(2'd1, 2'd1, 1'b1, 32'd100);
		push_sample(2'd1, 2'd1, 1'b1, 32'd1101);        // just over max, dropped
		push_sample(2'd1, 2'd1, 1'b1, 32'd1150);
		push_sample(2'd1, 2'd1, 1'b1, 32'd1200);
		push_sample(2'd1, 2'd1, 1'b1, 32'd1201);
		push_sample(2'd1, 2'd3, 1'b0, 32'd0);
		push_sample(2'd1, 2'd3, 1'b0, 32'hFFFF_FFFF);
		push_sample(2'd2, 2'd2, 1'b1, 32'h8000_0000);
		push_sample(2'd2, 2'd2, 1'b0, 32'h8000_0040);
		push_sample(2'd2, 2'd2, 1'b1, 32'h8000_0100);
		// held key fires again and again
		push_sample(2'd0, 2'd3, 1'b1, 32'h0000_1000);
		push_sample(2'd0, 2'd3, 1'b1, 32'h0000_1040);
		push_sample(2'd0, 2'd3, 1'b1, 32'h0000_1080);
		push_sample(2'd0, 2'd3, 1'b1, 32'h0000_10C0);
		push_sample(2'd3, 2'd0, 1'b1, 32'h5555_5555);
		push_sample(2'd3, 2'd0, 1'b1, 32'hAAAA_AAAA);
		push_sample(2'd2, 2'd1, 1'b1, 32'hFFFF_FFFF);
		push_sample(2'd2, 2'd1, 1'b1, 32'h0000_0033);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			pol_word    = (kpwd_pkg::CFG_DATA_W)'($urandom);
			pol_word[0] = set_low[p];
			cfg_write(kpwd_pkg::REG_PRESS_MIN, (kpwd_pkg::CFG_DATA_W)'(set_min[p]));
			cfg_write(kpwd_pkg::REG_PRESS_MAX, (kpwd_pkg::CFG_DATA_W)'(set_max[p]));
			cfg_write(kpwd_pkg::REG_ACTIVE_LOW, pol_word);
			if (p == 1)
				cfg_write(REG_SPARE, 16'hFFFF);
			@(negedge clk);
			if (p < 2) begin
				snd_idle_pct <= 7;
				rcv_idle_pct <= 45;
			end else if (p < 4) begin
				snd_idle_pct <= 45;
				rcv_idle_pct <= 7;
			end else begin
				snd_idle_pct <= 0;
				rcv_idle_pct <= 0;
			end
			if (p == 1)
				hold_arm <= 1'b1;
			while (scan_q.size() < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < 15)
					push_noise($urandom);
				else
					queue_press_attempt();
			end
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (press_q.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", press_q.size()));
		if (err_cnt == 0)
			$display("keypad_press_window_detector test passed");
		else
			$display("keypad_press_window_detector test failed");
		$finish;
	end

endmodule
